// ===== rtl/ucrr_pkg.sv =====
// Shared types, codes and descriptor ROM for the USB control request responder.
// No dependencies; imported by every module in rtl/.
package ucrr_pkg;

    localparam int PACKET_BYTES = 32;
    localparam int PKT_W        = $clog2(PACKET_BYTES);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] REQ_SET_ADDRESS = 8'd5;
    localparam logic [7:0] REQ_GET_DESC    = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIG  = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIG  = 8'd9;

    localparam logic [7:0] DESC_DEVICE = 8'd1;
    localparam logic [7:0] DESC_CONFIG = 8'd2;

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_EMPTY  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;
    localparam logic [1:0] KIND_STALL  = 2'd3;

    localparam logic [1:0] OP_STREAM = 2'd0;
    localparam logic [1:0] OP_REPLY  = 2'd1;
    localparam logic [1:0] OP_GETCFG = 2'd2;

    localparam logic [5:0] DEV_BASE = 6'd0;
    localparam logic [5:0] DEV_SIZE = 6'd18;
    localparam logic [5:0] CFG_BASE = 6'd18;
    localparam logic [5:0] CFG_SIZE = 6'd32;

    typedef struct packed {
        logic [1:0] op;
        logic [1:0] kind;
        logic [5:0] base;
        logic [5:0] count;
        logic       set_addr;
        logic       set_cfg;
        logic [6:0] value;
    } cmd_t;

    function automatic logic [7:0] rom_byte(input logic [5:0] a);
        logic [7:0] d;
        case (a)
            6'd0:  d = 8'h12;  6'd1:  d = 8'h01;  6'd2:  d = 8'h10;  6'd3:  d = 8'h01;
            6'd4:  d = 8'hDC;  6'd5:  d = 8'h00;  6'd6:  d = 8'h00;  6'd7:  d = 8'h20;
            6'd8:  d = 8'h05;  6'd9:  d = 8'h80;  6'd10: d = 8'h00;  6'd11: d = 8'h10;
            6'd12: d = 8'h00;  6'd13: d = 8'h00;  6'd14: d = 8'h00;  6'd15: d = 8'h00;
            6'd16: d = 8'h00;  6'd17: d = 8'h01;  6'd18: d = 8'h09;  6'd19: d = 8'h02;
            6'd20: d = 8'h20;  6'd21: d = 8'h00;  6'd22: d = 8'h01;  6'd23: d = 8'h01;
            6'd24: d = 8'h00;  6'd25: d = 8'h80;  6'd26: d = 8'hFA;  6'd27: d = 8'h09;
            6'd28: d = 8'h04;  6'd29: d = 8'h00;  6'd30: d = 8'h00;  6'd31: d = 8'h02;
            6'd32: d = 8'hDC;  6'd33: d = 8'hAC;  6'd34: d = 8'hBC;  6'd35: d = 8'h00;
            6'd36: d = 8'h07;  6'd37: d = 8'h05;  6'd38: d = 8'h81;  6'd39: d = 8'h02;
            6'd40: d = 8'h20;  6'd41: d = 8'h00;  6'd42: d = 8'h00;  6'd43: d = 8'h07;
            6'd44: d = 8'h05;  6'd45: d = 8'h02;  6'd46: d = 8'h02;  6'd47: d = 8'h20;
            6'd48: d = 8'h00;  6'd49: d = 8'h00;
            default: d = 8'h00;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/ucrr_front.sv =====
// Request decoder: accepts setup requests and queues commands; set-config with nonzero rtype is dropped.
// Depends on ucrr_pkg.
module ucrr_front
    import ucrr_pkg::*;
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // request_type, request_code, value_low, value_high, requested_length
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    logic [7:0]  rtype;
    logic [7:0]  code;
    logic [7:0]  vlow;
    logic [7:0]  vhigh;
    logic [15:0] wlen;
    logic [5:0]  size;
    logic [5:0]  count;
    logic        drop;

    assign rtype = s_tdata[7:0];
    assign code  = s_tdata[15:8];
    assign vlow  = s_tdata[23:16];
    assign vhigh = s_tdata[31:24];
    assign wlen  = s_tdata[47:32];

    assign size  = (vhigh == DESC_DEVICE) ? DEV_SIZE : CFG_SIZE;
    assign count = (wlen < {10'd0, size}) ? wlen[5:0] : size;

    always_comb begin
        q_cmd          = '0;
        q_cmd.op       = OP_REPLY;
        q_cmd.kind     = KIND_STALL;
        q_cmd.value    = vlow[6:0];
        drop           = 1'b0;
        unique case (code)
            REQ_GET_DESC: begin
                if (vhigh == DESC_DEVICE || vhigh == DESC_CONFIG) begin
                    q_cmd.base  = (vhigh == DESC_DEVICE) ? DEV_BASE : CFG_BASE;
                    q_cmd.count = count;
                    if (count == 6'd0) begin
                        q_cmd.kind = KIND_EMPTY;
                    end else begin
                        q_cmd.op   = OP_STREAM;
                        q_cmd.kind = KIND_DATA;
                    end
                end
            end
            REQ_GET_CONFIG: begin
                q_cmd.op   = OP_GETCFG;
                q_cmd.kind = KIND_DATA;
            end
            REQ_SET_ADDRESS: begin
                q_cmd.kind     = KIND_STATUS;
                q_cmd.set_addr = 1'b1;
            end
            REQ_SET_CONFIG: begin
                if (rtype != 8'd0) begin
                    drop = 1'b1;
                end else if (vlow <= 8'd1) begin
                    q_cmd.kind    = KIND_STATUS;
                    q_cmd.set_cfg = 1'b1;
                end
            end
            default: begin
                q_cmd.kind = KIND_STALL;
            end
        endcase
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready && !drop;

endmodule

// ===== rtl/ucrr_queue.sv =====
// Short command queue between the request decoder and the reply engine.
// Depends on ucrr_pkg.
module ucrr_queue
    import ucrr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  cmd_t              push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output cmd_t              pop_cmd,
    output logic [QCNT_W-1:0] level
);

    cmd_t              mem [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid   = (cnt_reg != '0);
    assign pop_cmd = mem[rd_ptr_reg];
    assign level   = cnt_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== rtl/ucrr_back.sv =====
// Reply engine: holds address/configuration state and emits result transactions.
// Depends on ucrr_pkg; descriptor bytes come from ucrr_pkg::rom_byte.
module ucrr_back
    import ucrr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // data_byte, packet_end, device_address, configured, zero pad
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // reply_kind
);

    logic             busy_reg, busy_next;
    logic [1:0]       op_reg, op_next;
    logic [1:0]       kind_reg, kind_next;
    logic [5:0]       base_reg, base_next;
    logic [5:0]       count_reg, count_next;
    logic [5:0]       idx_reg, idx_next;
    logic [PKT_W-1:0] pkt_reg, pkt_next;
    logic [6:0]       addr_reg, addr_next;
    logic             cfg_reg, cfg_next;

    logic             m_valid_reg, m_valid_next;
    logic [1:0]       m_kind_reg, m_kind_next;
    logic [7:0]       m_byte_reg, m_byte_next;
    logic             m_pend_reg, m_pend_next;
    logic             m_last_reg, m_last_next;
    logic [6:0]       m_addr_reg, m_addr_next;
    logic             m_cfg_reg, m_cfg_next;

    logic             out_free;
    logic             fin;
    logic             pkt_wrap;

    assign out_free = !m_valid_reg || m_tready;
    assign q_pop    = !busy_reg && q_valid;
    assign fin      = (idx_reg == count_reg - 6'd1);
    assign pkt_wrap = (pkt_reg == PKT_W'(PACKET_BYTES - 1));

    always_comb begin
        busy_next    = busy_reg;
        op_next      = op_reg;
        kind_next    = kind_reg;
        base_next    = base_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        pkt_next     = pkt_reg;
        addr_next    = addr_reg;
        cfg_next     = cfg_reg;
        m_valid_next = m_valid_reg;
        m_kind_next  = m_kind_reg;
        m_byte_next  = m_byte_reg;
        m_pend_next  = m_pend_reg;
        m_last_next  = m_last_reg;
        m_addr_next  = m_addr_reg;
        m_cfg_next   = m_cfg_reg;

        if (q_pop) begin
            busy_next  = 1'b1;
            op_next    = q_cmd.op;
            kind_next  = q_cmd.kind;
            base_next  = q_cmd.base;
            count_next = q_cmd.count;
            idx_next   = '0;
            pkt_next   = '0;
            if (q_cmd.set_addr) begin
                addr_next = q_cmd.value;
            end
            if (q_cmd.set_cfg) begin
                cfg_next = q_cmd.value[0];
            end
        end

        if (out_free) begin
            m_valid_next = busy_reg;
            m_addr_next  = addr_reg;
            m_cfg_next   = cfg_reg;
            if (busy_reg) begin
                unique case (op_reg)
                    OP_STREAM: begin
                        m_kind_next = KIND_DATA;
                        m_byte_next = rom_byte(base_reg + idx_reg);
                        m_pend_next = fin || pkt_wrap;
                        m_last_next = fin;
                        idx_next    = idx_reg + 6'd1;
                        pkt_next    = pkt_wrap ? '0 : pkt_reg + 1'b1;
                        busy_next   = !fin;
                    end
                    OP_GETCFG: begin
                        m_kind_next = KIND_DATA;
                        m_byte_next = {7'd0, cfg_reg};
                        m_pend_next = 1'b1;
                        m_last_next = 1'b1;
                        busy_next   = 1'b0;
                    end
                    default: begin
                        m_kind_next = kind_reg;
                        m_byte_next = 8'd0;
                        m_pend_next = (kind_reg == KIND_EMPTY);
                        m_last_next = 1'b1;
                        busy_next   = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            addr_reg    <= '0;
            cfg_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            addr_reg    <= addr_next;
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        kind_reg   <= kind_next;
        base_reg   <= base_next;
        count_reg  <= count_next;
        idx_reg    <= idx_next;
        pkt_reg    <= pkt_next;
        m_kind_reg <= m_kind_next;
        m_byte_reg <= m_byte_next;
        m_pend_reg <= m_pend_next;
        m_last_reg <= m_last_next;
        m_addr_reg <= m_addr_next;
        m_cfg_reg  <= m_cfg_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_cfg_reg, m_addr_reg, m_pend_reg, m_byte_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_kind_reg;

endmodule

// ===== rtl/usb_control_request_responder_top.sv =====
// Path: command queue entry, reply engine command registers, then the registered output.
// The reply engine pops the next command only when idle and sends descriptors byte by byte.
// Setup transactions are taken while the 2-entry command queue has room.
// Reset (aresetn low, synchronous) clears address, configuration, queue and output.
// Top level: decoder, command queue and reply engine. Depends on ucrr_pkg and the ucrr_* modules.
module usb_control_request_responder_top
    import ucrr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // request_type, request_code, value_low, value_high, requested_length
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // data_byte, packet_end, device_address, configured, zero pad
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // reply_kind
);

    logic              q_full;
    logic              q_push;
    cmd_t              q_in;
    logic              q_pop;
    logic              q_valid;
    cmd_t              q_out;
    logic [QCNT_W-1:0] q_level;

    ucrr_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_in)
    );

    ucrr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_cmd  (q_out),
        .level    (q_level)
    );

    ucrr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_nondata_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_DATA) |-> m_tlast)
        else $error("non-data reply not marked last");

    a_last_ends_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast && (m_tuser == KIND_DATA || m_tuser == KIND_EMPTY))
            |-> m_tdata[8])
        else $error("final data transaction without packet end");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_level <= QCNT_W'(QUEUE_DEPTH)) && !(q_push && q_full))
        else $error("command queue overflow");

endmodule

// ===== tb/sv/ucrr_reply_checker.sv =====
`timescale 1ns / 1ps
// Reply checker for usb_control_request_responder_top: predicts every reply of each
// accepted setup transaction and compares it with the result channel field by field.
// Depends on ucrr_pkg for request codes, reply kinds and descriptor layout.
module ucrr_reply_checker
    import ucrr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tlast,
    input  logic [1:0]  m_tuser,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       packet_end;
        logic       is_last;
        logic [6:0] address;
        logic       configured;
    } reply_t;

    reply_t     reply_q[$];
    logic [7:0] desc_rom [0:49];
    logic [6:0] dev_addr;
    logic       cfg_num;

    initial begin
        errors   = 0;
        pending  = 0;
        dev_addr = '0;
        cfg_num  = 1'b0;
        desc_rom = '{8'h12, 8'h01, 8'h10, 8'h01, 8'hDC, 8'h00, 8'h00, 8'h20, 8'h05,
                     8'h80, 8'h00, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
                     8'h09, 8'h02, 8'h20, 8'h00, 8'h01, 8'h01, 8'h00, 8'h80, 8'hFA,
                     8'h09, 8'h04, 8'h00, 8'h00, 8'h02, 8'hDC, 8'hAC, 8'hBC, 8'h00,
                     8'h07, 8'h05, 8'h81, 8'h02, 8'h20, 8'h00, 8'h00,
                     8'h07, 8'h05, 8'h02, 8'h02, 8'h20, 8'h00, 8'h00};
    end

    function automatic void push_reply(input logic [1:0] kind, input logic [7:0] data_byte,
                                       input logic packet_end, input logic is_last);
        reply_t r;
        r.kind       = kind;
        r.data_byte  = data_byte;
        r.packet_end = packet_end;
        r.is_last    = is_last;
        r.address    = dev_addr;
        r.configured = cfg_num;
        reply_q.push_back(r);
    endfunction

    function automatic void predict_reply(input logic [47:0] req);
        logic [7:0]  rtype, code, vlow, vhigh;
        logic [15:0] wlen;
        int          base, size, count, i;
        rtype = req[7:0];
        code  = req[15:8];
        vlow  = req[23:16];
        vhigh = req[31:24];
        wlen  = req[47:32];
        case (code)
            REQ_GET_DESC: begin
                if (vhigh == DESC_DEVICE) begin
                    base = DEV_BASE;
                    size = DEV_SIZE;
                end else if (vhigh == DESC_CONFIG) begin
                    base = CFG_BASE;
                    size = CFG_SIZE;
                end else begin
                    size = 0;
                end
                if (size == 0) begin
                    push_reply(KIND_STALL, 8'h00, 1'b0, 1'b1);
                end else begin
                    count = (int'(wlen) < size) ? int'(wlen) : size;
                    if (count == 0)
                        push_reply(KIND_EMPTY, 8'h00, 1'b1, 1'b1);
                    for (i = 0; i < count; i++)
                        push_reply(KIND_DATA, desc_rom[base + i],
                                   (i + 1 == count) || ((i + 1) % PACKET_BYTES == 0),
                                   i + 1 == count);
                end
            end
            REQ_GET_CONFIG: push_reply(KIND_DATA, {7'b0, cfg_num}, 1'b1, 1'b1);
            REQ_SET_ADDRESS: begin
                dev_addr = vlow[6:0];
                push_reply(KIND_STATUS, 8'h00, 1'b0, 1'b1);
            end
            REQ_SET_CONFIG: begin
                // non-standard request type on set-config is dropped silently
                if (rtype == 8'h00) begin
                    if (vlow <= 8'd1) begin
                        cfg_num = vlow[0];
                        push_reply(KIND_STATUS, 8'h00, 1'b0, 1'b1);
                    end else begin
                        push_reply(KIND_STALL, 8'h00, 1'b0, 1'b1);
                    end
                end
            end
            default: push_reply(KIND_STALL, 8'h00, 1'b0, 1'b1);
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            errors++;
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        end
    endfunction

    always @(posedge aclk) begin : monitor
        reply_t exp_r;
        if (!aresetn) begin
            dev_addr = '0;
            cfg_num  = 1'b0;
            reply_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (reply_q.size() == 0) begin
                    errors++;
                    $error("result transaction with no reply awaited: tdata %h", m_tdata);
                end else begin
                    exp_r = reply_q.pop_front();
                    check_field("reply_kind", exp_r.kind, m_tuser);
                    check_field("data_byte", exp_r.data_byte, m_tdata[7:0]);
                    check_field("packet_end", exp_r.packet_end, m_tdata[8]);
                    check_field("last", exp_r.is_last, m_tlast);
                    check_field("device_address", exp_r.address, m_tdata[15:9]);
                    check_field("configured", exp_r.configured, m_tdata[16]);
                    check_field("tdata pad", 0, m_tdata[23:17]);
                end
            end
            if (s_tvalid && s_tready)
                predict_reply(s_tdata);
        end
        pending = reply_q.size();
    end

endmodule

// ===== tb/sv/tb_usb_control_request_responder_top.sv =====
`timescale 1ns / 1ps
// Testbench top for usb_control_request_responder_top: clock, reset, setup request
// stimulus with sender gaps and receiver stalls, and the final verdict.
// Depends on ucrr_pkg, the RTL and ucrr_reply_checker.
module tb_usb_control_request_responder_top
    import ucrr_pkg::*;
();

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    int fail_count;
    int awaited;
    int send_idle;
    int recv_stall;
    bit hold_req;

    usb_control_request_responder_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    ucrr_reply_checker reply_check (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .errors   (fail_count),
        .pending  (awaited)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (400) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    function automatic logic [47:0] pack_req(input logic [7:0] rtype, input logic [7:0] code,
                                             input logic [7:0] vlow, input logic [7:0] vhigh,
                                             input logic [15:0] wlen);
        return {wlen, vhigh, vlow, code, rtype};
    endfunction

    function automatic logic [15:0] rand_len();
        case ($urandom_range(9))
            0:          return 16'd0;
            1, 2, 3, 4: return 16'($urandom_range(40));
            5:          return 16'($urandom_range(34, 16));
            default:    return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [47:0] rand_request();
        int         pick;
        logic [7:0] rtype, code, vlow, vhigh;
        pick  = $urandom_range(99);
        rtype = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'h80;
        vlow  = 8'($urandom_range(255));
        vhigh = 8'($urandom_range(255));
        if (pick < 40) begin
            code = REQ_GET_DESC;
            if (pick < 36)
                vhigh = (pick % 2) ? DESC_DEVICE : DESC_CONFIG;
        end else if (pick < 55) begin
            code = REQ_SET_ADDRESS;
        end else if (pick < 72) begin
            code = REQ_SET_CONFIG;
            if ($urandom_range(4) != 0)
                rtype = 8'h00;
            if ($urandom_range(3) != 0)
                vlow = 8'($urandom_range(1));
        end else if (pick < 85) begin
            code = REQ_GET_CONFIG;
        end else begin
            code = 8'($urandom_range(255));
        end
        return pack_req(rtype, code, vlow, vhigh, rand_len());
    endfunction

    // called and returns at a falling edge
    task automatic send_req(input logic [47:0] req);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (awaited != 0);
    endtask

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        send_idle  = 0;
        recv_stall = 0;
        hold_req   = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_req(pack_req(8'h80, REQ_GET_DESC, 8'h00, DESC_DEVICE, 16'd0));
        send_req(pack_req(8'h80, REQ_GET_DESC, 8'h00, DESC_DEVICE, 16'd1));
        send_req(pack_req(8'h80, REQ_GET_DESC, 8'h00, DESC_DEVICE, 16'd18));
        send_req(pack_req(8'h80, REQ_GET_DESC, 8'hFF, DESC_DEVICE, 16'hFFFF));
        send_req(pack_req(8'h80, REQ_GET_DESC, 8'h00, DESC_CONFIG, 16'd0));
        send_req(pack_req(8'h80, REQ_GET_DESC, 8'h00, DESC_CONFIG, 16'd9));
        send_req(pack_req(8'h80, REQ_GET_DESC, 8'h00, DESC_CONFIG, 16'd31));
        send_req(pack_req(8'h80, REQ_GET_DESC, 8'h00, DESC_CONFIG, 16'd32));
        send_req(pack_req(8'h80, REQ_GET_DESC, 8'h03, DESC_CONFIG, 16'd33));
        send_req(pack_req(8'hFF, REQ_GET_DESC, 8'h00, DESC_CONFIG, 16'hFFFF));
        send_req(pack_req(8'h80, REQ_GET_DESC, 8'h00, 8'h00, 16'd64));
        send_req(pack_req(8'h80, REQ_GET_DESC, 8'h00, 8'h03, 16'd64));
        send_req(pack_req(8'h80, REQ_GET_DESC, 8'h00, 8'hFF, 16'd64));
        send_req(pack_req(8'h00, REQ_SET_ADDRESS, 8'h7F, 8'h00, 16'd0));
        send_req(pack_req(8'hFF, REQ_SET_ADDRESS, 8'hFF, 8'hFF, 16'hFFFF));
        send_req(pack_req(8'h80, REQ_SET_ADDRESS, 8'h2A, 8'h00, 16'd0));
        send_req(pack_req(8'h00, REQ_SET_CONFIG, 8'h01, 8'h00, 16'd0));
        send_req(pack_req(8'h80, REQ_GET_CONFIG, 8'h00, 8'h00, 16'd0));
        send_req(pack_req(8'h01, REQ_SET_CONFIG, 8'h00, 8'h00, 16'd0));
        send_req(pack_req(8'h00, REQ_SET_CONFIG, 8'h02, 8'h00, 16'd0));
        send_req(pack_req(8'h00, REQ_SET_CONFIG, 8'hFF, 8'h00, 16'd0));
        send_req(pack_req(8'hFF, REQ_GET_CONFIG, 8'hFF, 8'hFF, 16'hFFFF));
        send_req(pack_req(8'h00, REQ_SET_CONFIG, 8'h00, 8'h00, 16'd0));
        send_req(pack_req(8'h00, 8'h00, 8'h00, 8'h00, 16'd0));
        send_req(pack_req(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
        wait_drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle = 0;  recv_stall = 0;  end
                1:       begin send_idle = 78; recv_stall = 0;  end
                2:       begin send_idle = 0;  recv_stall = 78; end
                default: begin send_idle = 9;  recv_stall = 9;  end
            endcase
            repeat (55) send_req(rand_request());
            if (phase == 1) begin
                // long result hold-off while requests keep coming, then a full drain
                send_idle = 0;
                hold_req  = 1'b1;
                repeat (20) send_req(rand_request());
                wait_drain();
            end
        end

        recv_stall = 0;
        wait_drain();
        repeat (40) @(negedge aclk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
